>>> rtl/rn_pkg.sv
// Shared types, codes and letter tables for the integer to Roman numeral block.
// No dependencies; imported by every module of the block.
package rn_pkg;

  localparam int unsigned VALUE_W = 12;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned STAT_W  = 2;

  localparam logic [VALUE_W-1:0] VALUE_LIMIT = 12'd4000;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // letter slots within one decade
  localparam logic [1:0] SLOT_UNIT = 2'd0;
  localparam logic [1:0] SLOT_FIVE = 2'd1;
  localparam logic [1:0] SLOT_TEN  = 2'd2;

  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_NONE = 7'h00;
  localparam char_t CH_I    = 7'h49;
  localparam char_t CH_V    = 7'h56;
  localparam char_t CH_X    = 7'h58;
  localparam char_t CH_L    = 7'h4C;
  localparam char_t CH_C    = 7'h43;
  localparam char_t CH_D    = 7'h44;
  localparam char_t CH_M    = 7'h4D;

  // decimal digits of one item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [1:0]        thou;
    logic [3:0]        hund;
    logic [3:0]        tens;
    logic [3:0]        ones;
  } rn_digits_t;

  // letter groups per decade, index 3 = thousands
  typedef struct packed {
    logic [STAT_W-1:0]      status;
    logic [3:0][2:0]        len;
    char_t [3:0][3:0]       chars;
  } rn_groups_t;

  function automatic char_t decade_letter(input logic [1:0] dec, input logic [1:0] slot);
    char_t ch;
    ch = CH_M;
    case (dec)
      2'd0: begin
        ch = (slot == SLOT_UNIT) ? CH_I : (slot == SLOT_FIVE) ? CH_V : CH_X;
      end
      2'd1: begin
        ch = (slot == SLOT_UNIT) ? CH_X : (slot == SLOT_FIVE) ? CH_L : CH_C;
      end
      2'd2: begin
        ch = (slot == SLOT_UNIT) ? CH_C : (slot == SLOT_FIVE) ? CH_D : CH_M;
      end
      default: begin
        ch = CH_M;
      end
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] digit_len(input logic [3:0] dig);
    logic [2:0] n;
    n = 3'd2;
    case (dig)
      4'd0: n = 3'd0;
      4'd1: n = 3'd1;
      4'd2: n = 3'd2;
      4'd3: n = 3'd3;
      4'd4: n = 3'd2;
      4'd5: n = 3'd1;
      4'd6: n = 3'd2;
      4'd7: n = 3'd3;
      4'd8: n = 3'd4;
      default: n = 3'd2;
    endcase
    return n;
  endfunction

  function automatic logic [1:0] digit_slot(input logic [3:0] dig, input logic [1:0] pos);
    logic [1:0] s;
    s = SLOT_UNIT;
    case (dig)
      4'd0, 4'd1, 4'd2, 4'd3: s = SLOT_UNIT;
      4'd4: s = (pos == 2'd1) ? SLOT_FIVE : SLOT_UNIT;
      4'd5, 4'd6, 4'd7, 4'd8: s = (pos == 2'd0) ? SLOT_FIVE : SLOT_UNIT;
      default: s = (pos == 2'd1) ? SLOT_TEN : SLOT_UNIT;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/int_to_roman_numeral.sv
// Integer to Roman numeral converter, top level.
// Depends on rn_pkg, rn_digits, rn_pattern and rn_serial.
//
// Raise start with in_value while busy is low to transfer one value. The numeral
// comes out one ASCII letter per cycle on out_char_code, most significant first,
// each letter marked by a one-cycle out_valid strobe, the final one with out_last.
// Zero gives a single result with out_status ST_ZERO, values of 4000 or more a
// single result with ST_RANGE; both carry char code 0. The receiver cannot stall:
// every strobed result must be taken in that cycle. The first letter appears after
// the value has passed three split stages, the pattern stage and the serializer.
// A numeral has 1 to 15 letters (15 for 3888); the serializer accepts the next
// item while it emits the last letter of the current one. busy rises when the
// pipeline behind the serializer is full.
module int_to_roman_numeral (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [rn_pkg::VALUE_W-1:0] in_value,
  output logic                       out_valid,
  output logic [rn_pkg::CHAR_W-1:0]  out_char_code,
  output logic                       out_last,
  output logic [rn_pkg::STAT_W-1:0]  out_status
);
  import rn_pkg::*;

  logic       in_ready;
  logic       dig_valid, dig_ready;
  rn_digits_t dig_item;
  logic       grp_valid, grp_ready;
  rn_groups_t grp_item;

  assign busy = !in_ready;

  rn_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_value (in_value),
    .in_ready (in_ready),
    .dn_valid (dig_valid),
    .dn_item  (dig_item),
    .dn_ready (dig_ready)
  );

  rn_pattern u_pattern (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (dig_valid),
    .up_item  (dig_item),
    .up_ready (dig_ready),
    .dn_valid (grp_valid),
    .dn_item  (grp_item),
    .dn_ready (grp_ready)
  );

  rn_serial u_serial (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (grp_valid),
    .up_item       (grp_item),
    .up_ready      (grp_ready),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last),
    .out_status    (out_status)
  );

endmodule

>>> rtl/rn_digits.sv
// Three-stage decimal split: thousands, then hundreds, then tens and ones.
// Depends on rn_pkg.
module rn_digits (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [rn_pkg::VALUE_W-1:0] in_value,
  output logic                       in_ready,
  output logic                       dn_valid,
  output rn_pkg::rn_digits_t         dn_item,
  input  logic                       dn_ready
);
  import rn_pkg::*;

  // stage a: status, thousands, remainder below 1000
  logic              a_valid_r;
  logic [STAT_W-1:0] a_status_r, a_status_nxt;
  logic [1:0]        a_thou_r, a_thou_nxt;
  logic [9:0]        a_rem_r, a_rem_nxt;
  // stage b: hundreds, remainder below 100
  logic              b_valid_r;
  logic [STAT_W-1:0] b_status_r;
  logic [1:0]        b_thou_r;
  logic [3:0]        b_hund_r, b_hund_nxt;
  logic [6:0]        b_rem_r, b_rem_nxt;
  // stage c: tens and ones
  logic              c_valid_r;
  rn_digits_t        c_item_r, c_item_nxt;

  logic ready_a, ready_b, ready_c;

  assign ready_c  = !c_valid_r || dn_ready;
  assign ready_b  = !b_valid_r || ready_c;
  assign ready_a  = !a_valid_r || ready_b;
  assign in_ready = ready_a;

  always_comb begin
    logic [VALUE_W-1:0] sub;
    a_status_nxt = ST_OK;
    if (in_value >= VALUE_LIMIT) begin
      a_status_nxt = ST_RANGE;
    end else if (in_value == '0) begin
      a_status_nxt = ST_ZERO;
    end
    if (in_value >= 12'd3000) begin
      a_thou_nxt = 2'd3;
      sub        = 12'd3000;
    end else if (in_value >= 12'd2000) begin
      a_thou_nxt = 2'd2;
      sub        = 12'd2000;
    end else if (in_value >= 12'd1000) begin
      a_thou_nxt = 2'd1;
      sub        = 12'd1000;
    end else begin
      a_thou_nxt = 2'd0;
      sub        = 12'd0;
    end
    // out-of-range values wrap here; status marks them
    a_rem_nxt = 10'(in_value - sub);
  end

  always_comb begin
    logic [9:0] sub;
    b_hund_nxt = 4'd0;
    sub        = 10'd0;
    for (int k = 1; k < 10; k++) begin
      if (a_rem_r >= 10'(k * 100)) begin
        b_hund_nxt = 4'(k);
        sub        = 10'(k * 100);
      end
    end
    b_rem_nxt = 7'(a_rem_r - sub);
  end

  always_comb begin
    logic [6:0] sub;
    c_item_nxt.status = b_status_r;
    c_item_nxt.thou   = b_thou_r;
    c_item_nxt.hund   = b_hund_r;
    c_item_nxt.tens   = 4'd0;
    sub               = 7'd0;
    for (int k = 1; k < 10; k++) begin
      if (b_rem_r >= 7'(k * 10)) begin
        c_item_nxt.tens = 4'(k);
        sub             = 7'(k * 10);
      end
    end
    c_item_nxt.ones = 4'(b_rem_r - sub);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (ready_a) begin
        a_valid_r <= in_valid;
      end
      if (ready_b) begin
        b_valid_r <= a_valid_r;
      end
      if (ready_c) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a) begin
      a_status_r <= a_status_nxt;
      a_thou_r   <= a_thou_nxt;
      a_rem_r    <= a_rem_nxt;
    end
    if (ready_b) begin
      b_status_r <= a_status_r;
      b_thou_r   <= a_thou_r;
      b_hund_r   <= b_hund_nxt;
      b_rem_r    <= b_rem_nxt;
    end
    if (ready_c) begin
      c_item_r <= c_item_nxt;
    end
  end

  assign dn_valid = c_valid_r;
  assign dn_item  = c_item_r;

endmodule

>>> rtl/rn_pattern.sv
// Pattern stage: turns each decimal digit into its group of numeral letters.
// Depends on rn_pkg.
module rn_pattern (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  rn_pkg::rn_digits_t up_item,
  output logic               up_ready,
  output logic               dn_valid,
  output rn_pkg::rn_groups_t dn_item,
  input  logic               dn_ready
);
  import rn_pkg::*;

  logic       valid_r;
  rn_groups_t item_r, item_nxt;
  logic       ready_p;

  assign ready_p  = !valid_r || dn_ready;
  assign up_ready = ready_p;

  always_comb begin
    logic [3:0][3:0] dig;
    dig[3] = {2'b00, up_item.thou};
    dig[2] = up_item.hund;
    dig[1] = up_item.tens;
    dig[0] = up_item.ones;
    item_nxt.status = up_item.status;
    for (int d = 0; d < 4; d++) begin
      item_nxt.len[d] = digit_len(dig[d]);
      for (int j = 0; j < 4; j++) begin
        item_nxt.chars[d][j] = decade_letter(2'(d), digit_slot(dig[d], 2'(j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_p) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_p) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

>>> rtl/rn_serial.sv
// Serializer: walks the letter groups of one item and emits one letter per cycle.
// Depends on rn_pkg.
module rn_serial (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      up_valid,
  input  rn_pkg::rn_groups_t        up_item,
  output logic                      up_ready,
  output logic                      out_valid,
  output logic [rn_pkg::CHAR_W-1:0] out_char_code,
  output logic                      out_last,
  output logic [rn_pkg::STAT_W-1:0] out_status
);
  import rn_pkg::*;

  function automatic logic [1:0] top_set(input logic [3:0] m);
    logic [1:0] idx;
    idx = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (m[k]) begin
        idx = 2'(k);
      end
    end
    return idx;
  endfunction

  logic       hold_r, hold_nxt;
  rn_groups_t grp_r, grp_nxt;
  logic [1:0] dec_r, dec_nxt;
  logic [1:0] pos_r, pos_nxt;

  logic [3:0] ne_cur, ne_in, below;
  logic [2:0] cur_len;
  logic       end_grp, cur_last, take;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ne_cur[k] = (grp_r.len[k] != 3'd0);
      ne_in[k]  = (up_item.len[k] != 3'd0);
    end
    cur_len  = grp_r.len[dec_r];
    below    = ne_cur & ((4'd1 << dec_r) - 4'd1);
    end_grp  = ({1'b0, pos_r} == (cur_len - 3'd1));
    cur_last = (grp_r.status != ST_OK) || (end_grp && (below == 4'd0));
  end

  assign up_ready = !hold_r || cur_last;
  assign take     = up_valid && up_ready;

  always_comb begin
    hold_nxt = hold_r;
    grp_nxt  = grp_r;
    dec_nxt  = dec_r;
    pos_nxt  = pos_r;
    if (take) begin
      // load the next item as the current one finishes
      hold_nxt = 1'b1;
      grp_nxt  = up_item;
      dec_nxt  = top_set(ne_in);
      pos_nxt  = 2'd0;
    end else if (hold_r) begin
      if (cur_last) begin
        hold_nxt = 1'b0;
      end else if (end_grp) begin
        // skip empty decades
        dec_nxt = top_set(below);
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
    dec_r <= dec_nxt;
    pos_r <= pos_nxt;
  end

  assign out_valid     = hold_r;
  assign out_char_code = (grp_r.status == ST_OK) ? grp_r.chars[dec_r][pos_r] : CH_NONE;
  assign out_last      = cur_last;
  assign out_status    = grp_r.status;

endmodule
